@@ rtl/assert_macros.svh @@
// Assertion helper macros for the ARP cache block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACACHE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACACHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/acache_pkg.sv @@
// Shared constants and types for the ARP cache with aging.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package acache_pkg;

  localparam int ENTRIES   = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int AGE_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [AGE_W-1:0] AGE_LIMIT = 32'h0001_0000;
  localparam logic [AGE_W-1:0] AGE_MAX   = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_IP   = 2'd2;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic              learn;
    logic              hit;      // answer known, stop aging
    logic              routed;   // answer is the router MAC
    logic              fix;      // routed learn: first matching entry still to update
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  nmac;
    logic [MAC_W-1:0]  mac;
    logic [AGE_W-1:0]  oldest;   // eldest prior age seen during aging
    logic              inv_seen; // fill slot settled on an invalid entry
    logic [IDX_W-1:0]  slot;
    logic [AGE_W-1:0]  best;     // greatest post-scan age seen
  } token_t;

  // Fill data broadcast to the cells after a learn miss.
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } fill_t;

endpackage

@@ rtl/acache_ifs.sv @@
// Valid/ready channel interfaces for the ARP cache: lookup/learn input,
// result output and configuration write. Depends on acache_pkg.
`timescale 1ns / 1ps

interface acache_in_if;
  import acache_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [IP_W-1:0]  ip_addr;
  logic [MAC_W-1:0] new_mac;

  modport source (output valid, output op, output ip_addr, output new_mac, input ready);
  modport sink   (input valid, input op, input ip_addr, input new_mac, output ready);
endinterface

interface acache_out_if;
  import acache_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [MAC_W-1:0] mac_out;
  logic             via_router;
  logic             send_request;

  modport source (output valid, output found, output mac_out, output via_router,
                  output send_request, input ready);
  modport sink   (input valid, input found, input mac_out, input via_router,
                  input send_request, output ready);
endinterface

interface acache_cfg_if;
  import acache_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [IP_W-1:0]      data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/acache_cell.sv @@
// One cache entry of the ARP cache chain: holds valid, age, address and MAC,
// processes the passing token and registers it for the next cell. Uses acache_pkg.
`timescale 1ns / 1ps

module acache_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [acache_pkg::IDX_W-1:0] cell_idx,
  input  acache_pkg::token_t        tok_i,
  output acache_pkg::token_t        tok_o,
  input  logic                      fill_we,
  input  acache_pkg::fill_t         fill
);
  import acache_pkg::*;

  logic             valid_r, valid_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [IP_W-1:0]  ip_r, ip_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  token_t           tok_r, tok_nxt;

  always_comb begin
    logic             match;
    logic [AGE_W-1:0] aged;
    match     = valid_r && (ip_r == tok_i.ip);
    aged      = (age_r == AGE_MAX) ? age_r : age_r + 1'b1;
    valid_nxt = valid_r;
    age_nxt   = age_r;
    ip_nxt    = ip_r;
    mac_nxt   = mac_r;
    tok_nxt   = tok_i;

    if (tok_i.vld) begin
      if (match && !tok_i.hit) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.mac = mac_r;
        age_nxt     = '0;
        if (tok_i.learn) begin
          mac_nxt = tok_i.nmac;
        end
      end else if (match && tok_i.fix) begin
        age_nxt     = '0;
        mac_nxt     = tok_i.nmac;
        tok_nxt.fix = 1'b0;
      end else if (valid_r && !tok_i.hit) begin
        age_nxt = aged;
        if (age_r > tok_i.oldest) begin
          tok_nxt.oldest = age_r;
          if (age_r >= AGE_LIMIT) begin
            valid_nxt = 1'b0;
          end
        end
      end
      // Fill-slot choice on the post-scan state: first invalid, else oldest.
      if (!tok_i.inv_seen) begin
        if (!valid_nxt) begin
          tok_nxt.inv_seen = 1'b1;
          tok_nxt.slot     = cell_idx;
        end else if (age_nxt > tok_i.best) begin
          tok_nxt.best = age_nxt;
          tok_nxt.slot = cell_idx;
        end
      end
    end

    if (fill_we) begin
      valid_nxt = 1'b1;
      age_nxt   = '0;
      ip_nxt    = fill.ip;
      mac_nxt   = fill.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
    age_r <= age_nxt;
    ip_r  <= ip_nxt;
    mac_r <= mac_nxt;
  end

  assign tok_o = tok_r;

endmodule

@@ rtl/arp_cache_with_aging_unit.sv @@
// An input transaction is registered into the token register, walks the cell chain
// one entry per cycle, then is staged and registered out; learns of own/router address
// skip the chain. A new item waits until the last has left the chain and its result
// has moved to the output register; a result may wait there while the next item runs.
// Reset (synchronous, rst_n low): entry valid bits, router MAC and config registers
// clear at once; entry age/address/MAC are written on fill, no clearing pass.
`timescale 1ns / 1ps

module arp_cache_with_aging_unit (
  input  logic                clk,
  input  logic                rst_n,
  acache_in_if.sink           in_if,
  acache_out_if.source        out_if,
  acache_cfg_if.sink          cfg_if
);
  import acache_pkg::*;
  `include "assert_macros.svh"

  logic [IP_W-1:0]  own_ip_r, subnet_mask_r, router_ip_r;
  logic [MAC_W-1:0] router_mac_r;
  logic             inflight_r;
  token_t           tok0_r, tok0_nxt;

  logic             pend_valid_r;
  logic             pend_found_r, pend_via_r, pend_send_r;
  logic [MAC_W-1:0] pend_mac_r;

  logic             out_valid_r;
  logic             out_found_r, out_via_r, out_send_r;
  logic [MAC_W-1:0] out_mac_r;

  token_t           chain [ENTRIES+1];
  token_t           end_tok;
  logic [ENTRIES-1:0] fill_we;
  fill_t            fill;
  logic             fill_en;

  logic in_acc, is_own, is_rtr_learn, immediate, routed, out_load;

  assign in_if.ready  = !inflight_r && !pend_valid_r;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign is_own       = in_if.op && (in_if.ip_addr == own_ip_r);
  assign is_rtr_learn = in_if.op && !is_own && (in_if.ip_addr == router_ip_r);
  assign immediate    = is_own || is_rtr_learn;
  assign routed       = ((|((in_if.ip_addr ^ own_ip_r) & subnet_mask_r)) ||
                         (in_if.ip_addr == router_ip_r)) && (router_mac_r != '0);

  always_comb begin
    tok0_nxt          = '0;
    tok0_nxt.vld      = in_acc && !immediate;
    tok0_nxt.learn    = in_if.op;
    tok0_nxt.hit      = routed;
    tok0_nxt.routed   = routed;
    tok0_nxt.fix      = in_if.op && routed && (in_if.new_mac != router_mac_r);
    tok0_nxt.ip       = in_if.ip_addr;
    tok0_nxt.nmac     = in_if.new_mac;
    tok0_nxt.mac      = routed ? router_mac_r : '0;
  end

  // Cell chain
  assign chain[0] = tok0_r;
  assign end_tok  = chain[ENTRIES];

  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      acache_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(k)),
        .tok_i    (chain[k]),
        .tok_o    (chain[k+1]),
        .fill_we  (fill_we[k]),
        .fill     (fill)
      );
    end
  endgenerate

  // Learn miss: write the chosen slot when the token leaves the chain
  assign fill_en  = end_tok.vld && !end_tok.hit && end_tok.learn;
  assign fill.ip  = end_tok.ip;
  assign fill.mac = end_tok.nmac;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      fill_we[i] = fill_en && (end_tok.slot == IDX_W'(i));
    end
  end

  assign out_load = pend_valid_r && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      subnet_mask_r <= '0;
      router_ip_r   <= '0;
      router_mac_r  <= '0;
      inflight_r    <= 1'b0;
      tok0_r.vld    <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.idx)
          REG_OWN_IP:      own_ip_r      <= cfg_if.data;
          REG_SUBNET_MASK: subnet_mask_r <= cfg_if.data;
          REG_ROUTER_IP:   router_ip_r   <= cfg_if.data;
          default: ;
        endcase
      end

      if (in_acc && is_rtr_learn) begin
        router_mac_r <= in_if.new_mac;
      end

      tok0_r <= tok0_nxt;

      if (in_acc && !immediate) begin
        inflight_r <= 1'b1;
      end else if (end_tok.vld) begin
        inflight_r <= 1'b0;
      end

      if ((in_acc && immediate) || end_tok.vld) begin
        pend_valid_r <= 1'b1;
      end else if (out_load) begin
        pend_valid_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc && immediate) begin
      pend_found_r <= 1'b0;
      pend_mac_r   <= '0;
      pend_via_r   <= 1'b0;
      pend_send_r  <= 1'b0;
    end else if (end_tok.vld) begin
      pend_found_r <= end_tok.hit;
      pend_mac_r   <= end_tok.hit ? end_tok.mac : '0;
      pend_via_r   <= end_tok.hit && end_tok.routed;
      pend_send_r  <= !end_tok.hit;
    end

    if (out_load) begin
      out_found_r <= pend_found_r;
      out_mac_r   <= pend_mac_r;
      out_via_r   <= pend_via_r;
      out_send_r  <= pend_send_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.found        = out_found_r;
  assign out_if.mac_out      = out_mac_r;
  assign out_if.via_router   = out_via_r;
  assign out_if.send_request = out_send_r;

  // Assertions
  `ACACHE_ASSERT_NEXT(a_tok_enters, clk, rst_n, in_acc && !immediate, chain[0].vld,
    "accepted table transaction did not enter the cell chain")
  `ACACHE_ASSERT_NOW(a_end_inflight, clk, rst_n, end_tok.vld, inflight_r && !pend_valid_r,
    "token left the chain with no transaction in flight")
  `ACACHE_ASSERT_NOW(a_fill_onehot, clk, rst_n, 1'b1, $onehot0(fill_we),
    "more than one entry filled at once")
  `ACACHE_ASSERT_NOW(a_inflight_pend, clk, rst_n, inflight_r, !pend_valid_r,
    "staged result present while a lookup is in flight")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for arp_cache_with_aging_unit: lookup/learn stimulus
// with an in-bench cache predictor. Depends on acache_pkg and acache_ifs.
`timescale 1ns / 1ps

module tb;
  import acache_pkg::*;

  typedef enum logic {OP_LOOKUP = 1'b0, OP_LEARN = 1'b1} op_e;

  typedef struct {
    op_e              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    bit               drain_first;  // hold off until every answer is back
  } arp_req_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac;
    logic             via_router;
    logic             send_request;
  } arp_answer_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = ENTRIES + 3 + 20;
  localparam logic [IP_W-1:0] AGING_MISS_IP = 32'hC0A8_01F0;

  logic clk;
  logic rst_n;

  acache_in_if  in_ch ();
  acache_out_if out_ch ();
  acache_cfg_if cfg_ch ();

  arp_cache_with_aging_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Cache predictor state
  logic [IP_W-1:0]  cur_own_ip, cur_mask, cur_router_ip;
  bit               tbl_valid [ENTRIES];
  logic [AGE_W-1:0] tbl_age   [ENTRIES];
  logic [IP_W-1:0]  tbl_ip    [ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [ENTRIES];
  logic [MAC_W-1:0] known_router_mac;

  arp_req_t    request_q [$];
  arp_answer_t answer_q  [$];
  arp_req_t    cur_req;
  bit          in_busy;
  int          send_idle_pct;
  int          stall_pct;
  int          err_cnt;
  int          quiet_cycles;

  initial begin
    cur_own_ip       = '0;
    cur_mask         = '0;
    cur_router_ip    = '0;
    known_router_mac = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      tbl_valid[k] = 0;
      tbl_age[k]   = '0;
      tbl_ip[k]    = '0;
      tbl_mac[k]   = '0;
    end
  end

  task automatic report_mismatch(input string what, input logic [MAC_W-1:0] want,
                                 input logic [MAC_W-1:0] got);
    $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Router test, then in-order table scan with aging and eldest-based eviction.
  function automatic bit table_lookup(input logic [IP_W-1:0] ip,
                                      output logic [MAC_W-1:0] mac, output bit routed);
    logic [AGE_W-1:0] eldest;
    logic [AGE_W-1:0] prior;
    bit               hit;
    int               k;
    eldest = '0;
    mac    = '0;
    routed = 0;
    hit    = 0;
    if (((((ip ^ cur_own_ip) & cur_mask) != '0) || ip == cur_router_ip) &&
        known_router_mac != '0) begin
      mac    = known_router_mac;
      routed = 1;
      hit    = 1;
    end else begin
      for (k = 0; k < ENTRIES; k++) begin
        if (!hit && tbl_valid[k]) begin
          if (tbl_ip[k] == ip) begin
            tbl_age[k] = '0;
            mac        = tbl_mac[k];
            hit        = 1;
          end else begin
            prior = tbl_age[k];
            if (prior != AGE_MAX) tbl_age[k] = prior + 1'b1;
            if (prior > eldest) begin
              eldest = prior;
              if (prior >= AGE_LIMIT) tbl_valid[k] = 0;
            end
          end
        end
      end
    end
    return hit;
  endfunction

  // First free entry, else strictly oldest (lowest index on ties).
  function automatic int choose_fill_slot();
    logic [AGE_W-1:0] eldest;
    int               slot;
    int               k;
    bit               free_seen;
    eldest    = '0;
    slot      = 0;
    free_seen = 0;
    for (k = 0; k < ENTRIES; k++) begin
      if (!free_seen) begin
        if (!tbl_valid[k]) begin
          slot      = k;
          free_seen = 1;
        end else if (tbl_age[k] > eldest) begin
          eldest = tbl_age[k];
          slot   = k;
        end
      end
    end
    return slot;
  endfunction

  function automatic arp_answer_t predict_answer(input arp_req_t req);
    arp_answer_t ans;
    logic [MAC_W-1:0] mac;
    bit routed, hit, looked, done;
    int k;
    mac    = '0;
    routed = 0;
    hit    = 0;
    looked = 0;
    done   = 0;
    if (req.op == OP_LOOKUP) begin
      hit    = table_lookup(req.ip, mac, routed);
      looked = 1;
    end else if (req.ip == cur_own_ip) begin
      // learn of our own address is dropped
    end else if (req.ip == cur_router_ip) begin
      known_router_mac = req.mac;
    end else begin
      hit    = table_lookup(req.ip, mac, routed);
      looked = 1;
      if (hit) begin
        if (req.mac != mac) begin
          for (k = 0; k < ENTRIES; k++) begin
            if (!done && tbl_valid[k] && tbl_ip[k] == req.ip) begin
              tbl_age[k] = '0;
              tbl_mac[k] = req.mac;
              done       = 1;
            end
          end
        end
      end else begin
        k            = choose_fill_slot();
        tbl_age[k]   = '0;
        tbl_ip[k]    = req.ip;
        tbl_mac[k]   = req.mac;
        tbl_valid[k] = 1;
      end
    end
    ans.found        = hit;
    ans.mac          = hit ? mac : '0;
    ans.via_router   = hit && routed;
    ans.send_request = looked && !hit;
    return ans;
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_LOOKUP;
    in_ch.ip_addr = '0;
    in_ch.new_mac = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.idx    = REG_OWN_IP;
    cfg_ch.data   = '0;
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_busy = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        answer_q.push_back(predict_answer(cur_req));
        in_busy = 0;
      end
      if (!in_busy && request_q.size() > 0 &&
          !(request_q[0].drain_first && answer_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_req = request_q.pop_front();
        in_busy = 1;
        in_ch.valid   <= 1'b1;
        in_ch.op      <= cur_req.op;
        in_ch.ip_addr <= cur_req.ip;
        in_ch.new_mac <= cur_req.mac;
      end else if (!in_busy) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    arp_answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with none pending", '0, out_ch.mac_out);
        end else begin
          want = answer_q.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch("found", want.found, out_ch.found);
          if (out_ch.mac_out !== want.mac)
            report_mismatch("mac_out", want.mac, out_ch.mac_out);
          if (out_ch.via_router !== want.via_router)
            report_mismatch("via_router", want.via_router, out_ch.via_router);
          if (out_ch.send_request !== want.send_request)
            report_mismatch("send_request", want.send_request, out_ch.send_request);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL arp_cache_with_aging_unit");
    $finish;
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_busy || answer_q.size() != 0);
  endtask

  // Writes all three registers once the cache has drained.
  task automatic set_regs(input logic [IP_W-1:0] own, input logic [IP_W-1:0] mask,
                          input logic [IP_W-1:0] rtr);
    logic [CFG_IDX_W-1:0] idxs [3];
    logic [IP_W-1:0]      vals [3];
    int i;
    idxs = '{REG_OWN_IP, REG_SUBNET_MASK, REG_ROUTER_IP};
    vals = '{own, mask, rtr};
    wait_idle();
    @(posedge clk);
    for (i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.idx   <= idxs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk);
      while (!cfg_ch.ready);
      case (idxs[i])
        REG_OWN_IP:      cur_own_ip    = vals[i];
        REG_SUBNET_MASK: cur_mask      = vals[i];
        REG_ROUTER_IP:   cur_router_ip = vals[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_req(input op_e op, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input bit drain_first);
    arp_req_t req;
    req.op          = op;
    req.ip          = ip;
    req.mac         = mac;
    req.drain_first = drain_first;
    request_q.push_back(req);
  endtask

  // Mostly a small on-link/off-link address pool so hits, refreshes and
  // evictions recur; a few own/router and fully random addresses.
  task automatic queue_random(input int n, input int drain_every);
    logic [63:0]      r64;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  k;
    int sel, i;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      r64 = {$urandom, $urandom};
      k   = $urandom_range(12, 1);
      if (sel < 55)      ip = (cur_own_ip & cur_mask) | (k & ~cur_mask);
      else if (sel < 70) ip = 32'h0A00_0000 | (k & 32'h3);
      else if (sel < 78) ip = cur_own_ip;
      else if (sel < 86) ip = cur_router_ip;
      else               ip = $urandom;
      if ($urandom_range(99) < 40)
        mac = 48'h0200_0000_0000 | 48'($urandom_range(3));
      else if ($urandom_range(99) < 3)
        mac = '0;
      else
        mac = r64[MAC_W-1:0];
      queue_req($urandom_range(1) ? OP_LEARN : OP_LOOKUP, ip, mac,
                drain_every > 0 && (i % drain_every) == drain_every - 1);
    end
  endtask

  initial begin
    logic [IP_W-1:0] own;
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    err_cnt       = 0;
    @(posedge rst_n);

    // reset-valued registers: everything on-link, address 0 is own and router
    set_regs(32'h0, 32'h0, 32'h0);
    queue_req(OP_LOOKUP, 32'h0, '1, 0);
    queue_req(OP_LEARN, 32'h0, 48'h0000_0000_0001, 0);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, 0);

    set_regs(32'hC0A8_0101, 32'hFFFF_FF00, 32'hC0A8_01FE);
    queue_req(OP_LOOKUP, 32'h0808_0808, '0, 0);            // router unknown: table miss
    queue_req(OP_LEARN, 32'h0808_0808, 48'h0000_0000_0001, 0);
    queue_req(OP_LOOKUP, 32'h0808_0808, '0, 0);
    queue_req(OP_LEARN, 32'hC0A8_01FE, '1, 0);              // router MAC learned
    queue_req(OP_LOOKUP, 32'h0808_0808, '0, 0);
    queue_req(OP_LOOKUP, 32'hC0A8_01FE, '0, 0);
    queue_req(OP_LEARN, 32'h0808_0808, 48'h1234_5678_9ABC, 0); // routed hit refreshes entry
    queue_req(OP_LEARN, 32'hC0A8_0101, 48'hDEAD_BEEF_0001, 0); // own address dropped
    for (i = 0; i < 8; i++)                                   // fill, then evict oldest
      queue_req(OP_LEARN, 32'hC0A8_0110 + i, 48'h0200_0000_0000 + i, 0);
    queue_req(OP_LOOKUP, 32'hC0A8_0111, '0, 0);
    queue_req(OP_LEARN, 32'hC0A8_0112, 48'h0200_0000_0002, 0); // same MAC
    queue_req(OP_LEARN, 32'hC0A8_0113, 48'h0, 0);              // changed MAC
    queue_req(OP_LOOKUP, 32'hC0A8_0199, '0, 0);
    queue_req(OP_LEARN, 32'hC0A8_01FE, 48'h0, 0);              // router back to unknown
    queue_req(OP_LOOKUP, 32'h0808_0808, '1, 0);
    queue_req(OP_LOOKUP, 32'h0, '1, 0);

    queue_random(250, 0);

    set_regs(32'hFFFF_FFFF, 32'h0, 32'h0);
    send_idle_pct = 69;
    queue_random(250, 40);

    set_regs(32'h0A00_0001, 32'hFFFF_FFFF, 32'h0A00_00FE);
    send_idle_pct = 0;
    stall_pct     = 69;
    queue_random(250, 0);

    own = $urandom;
    set_regs(own, 32'hFFFF_0000, (own & 32'hFFFF_0000) | 32'h0000_FFFE);
    send_idle_pct = 34;
    stall_pct     = 34;
    queue_random(250, 60);

    // run of misses ages every valid entry
    set_regs(32'hC0A8_0101, 32'hFFFF_FF00, 32'hC0A8_01FE);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (i = 0; i < 20; i++)
      queue_req(OP_LOOKUP, AGING_MISS_IP, '0, 0);
    queue_random(40, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("PASS arp_cache_with_aging_unit");
    else
      $display("FAIL arp_cache_with_aging_unit");
    $finish;
  end

endmodule

@@ arp_cache_with_aging_unit.f @@
+incdir+rtl
rtl/acache_pkg.sv
rtl/acache_ifs.sv
rtl/acache_cell.sv
rtl/arp_cache_with_aging_unit.sv
bench/tb.sv
